>>> design/fat_cluster_chain_manager_unit_macros.svh
// Assertion macros for the cluster chain manager.
// Every macro samples on aclk and is held off while aresetn is low.
`ifndef FAT_CLUSTER_CHAIN_MANAGER_UNIT_MACROS_SVH
`define FAT_CLUSTER_CHAIN_MANAGER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define FCCM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fccm assertion failed");
// next-cycle implication
`define FCCM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fccm assertion failed");
`else
`define FCCM_ASSERT_IMP(label, ante, cons)
`define FCCM_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> design/fccm_pkg.sv
// Package for the cluster chain manager: constants, control word types
// and the microcode ROM. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fccm_pkg;

    localparam int DEFAULT_MAX_CLUSTERS = 4096;
    localparam int BYTES_PER_CLUSTER    = 512;
    localparam int CLUSTER_SHIFT        = $clog2(BYTES_PER_CLUSTER);

    localparam int HEAD_W = 16;
    localparam int BYTE_W = 22;
    localparam int CFG_W  = 13;
    localparam int NEED_W = BYTE_W + 1 - CLUSTER_SHIFT;

    localparam logic [HEAD_W-1:0] LINK_FREE = 16'h0000;
    localparam logic [HEAD_W-1:0] LINK_END  = 16'hffff;

    localparam logic [CFG_W-1:0] CLUSTERS_RESET = 13'd4096;

    // command codes carried in s_tuser
    localparam logic CMD_EXTEND = 1'b0;
    localparam logic CMD_FREE   = 1'b1;

    // status codes carried in m_tuser
    localparam logic STAT_OK       = 1'b0;
    localparam logic STAT_NO_SPACE = 1'b1;

    // microprogram step index
    typedef enum logic [4:0] {
        S_CLR       = 5'd0,
        S_IDLE      = 5'd1,
        S_DISP      = 5'd2,
        S_FREE_TEST = 5'd3,
        S_FREE_WR   = 5'd4,
        S_EXT_HEAD  = 5'd5,
        S_WALK_RD   = 5'd6,
        S_WALK_CHK  = 5'd7,
        S_WALK_ADV  = 5'd8,
        S_NEED_CHK  = 5'd9,
        S_GRAB_TEST = 5'd10,
        S_GRAB_CHK  = 5'd11,
        S_HIT       = 5'd12,
        S_NEWHEAD   = 5'd13,
        S_LINK      = 5'd14,
        S_FAIL      = 5'd15,
        S_EMIT      = 5'd16
    } step_t;

    typedef enum logic [1:0] {
        A_CUR   = 2'd0,
        A_SCAN  = 2'd1,
        A_PREV  = 2'd2,
        A_RDATA = 2'd3
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO = 2'd0,
        WD_END  = 2'd1,
        WD_PREV = 2'd2
    } wd_sel_t;

    typedef enum logic [1:0] {
        CUR_HOLD  = 2'd0,
        CUR_RDATA = 2'd1,
        CUR_PREV  = 2'd2
    } cur_op_t;

    typedef enum logic [3:0] {
        C_ALWAYS    = 4'd0,
        C_CLR_MORE  = 4'd1,
        C_NO_INPUT  = 4'd2,
        C_IS_FREE   = 4'd3,
        C_FREE_STOP = 4'd4,
        C_CUR_LINK  = 4'd5,
        C_WALK_STOP = 4'd6,
        C_ENOUGH    = 4'd7,
        C_SCAN_END  = 4'd8,
        C_RD_USED   = 4'd9,
        C_HEAD_OK   = 4'd10,
        C_OUT_BUSY  = 4'd11
    } cond_t;

    // one control word
    typedef struct packed {
        addr_sel_t addr_sel;
        logic      mem_we;
        wd_sel_t   wd_sel;
        logic      ready;
        cur_op_t   cur_op;
        logic      have_inc;
        logic      scan_inc;
        logic      head_load;
        logic      status_set;
        logic      emit;
        cond_t     cond;
        step_t     jump;
        step_t     next;
    } ctrl_t;

    // Microcode ROM: take jump when cond holds, otherwise next.
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        c = '0;
        c.addr_sel = A_CUR;
        c.wd_sel   = WD_ZERO;
        c.cur_op   = CUR_HOLD;
        c.cond     = C_ALWAYS;
        c.jump     = S_IDLE;
        c.next     = S_IDLE;
        unique case (s)
            S_CLR: begin
                c.addr_sel = A_SCAN; c.mem_we = 1'b1; c.wd_sel = WD_ZERO;
                c.scan_inc = 1'b1;
                c.cond = C_CLR_MORE; c.jump = S_CLR; c.next = S_IDLE;
            end
            S_IDLE: begin
                c.ready = 1'b1;
                c.cond = C_NO_INPUT; c.jump = S_IDLE; c.next = S_DISP;
            end
            S_DISP: begin
                c.cond = C_IS_FREE; c.jump = S_FREE_TEST; c.next = S_EXT_HEAD;
            end
            S_FREE_TEST: begin
                c.addr_sel = A_CUR;
                c.cond = C_FREE_STOP; c.jump = S_EMIT; c.next = S_FREE_WR;
            end
            S_FREE_WR: begin
                c.addr_sel = A_CUR; c.mem_we = 1'b1; c.wd_sel = WD_ZERO;
                c.cur_op = CUR_RDATA; c.have_inc = 1'b1;
                c.cond = C_ALWAYS; c.jump = S_FREE_TEST; c.next = S_FREE_TEST;
            end
            S_EXT_HEAD: begin
                c.cond = C_CUR_LINK; c.jump = S_WALK_RD; c.next = S_GRAB_TEST;
            end
            S_WALK_RD: begin
                c.addr_sel = A_CUR; c.head_load = 1'b1;
                c.cond = C_ALWAYS; c.jump = S_WALK_CHK; c.next = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                c.cond = C_WALK_STOP; c.jump = S_NEED_CHK; c.next = S_WALK_ADV;
            end
            S_WALK_ADV: begin
                c.addr_sel = A_RDATA; c.cur_op = CUR_RDATA; c.have_inc = 1'b1;
                c.cond = C_ALWAYS; c.jump = S_WALK_CHK; c.next = S_WALK_CHK;
            end
            S_NEED_CHK: begin
                c.cond = C_ENOUGH; c.jump = S_EMIT; c.next = S_GRAB_TEST;
            end
            S_GRAB_TEST: begin
                c.addr_sel = A_SCAN; c.scan_inc = 1'b1;
                c.cond = C_SCAN_END; c.jump = S_FAIL; c.next = S_GRAB_CHK;
            end
            S_GRAB_CHK: begin
                c.cond = C_RD_USED; c.jump = S_GRAB_TEST; c.next = S_HIT;
            end
            S_HIT: begin
                c.addr_sel = A_PREV; c.mem_we = 1'b1; c.wd_sel = WD_END;
                c.cond = C_HEAD_OK; c.jump = S_LINK; c.next = S_NEWHEAD;
            end
            S_NEWHEAD: begin
                c.cur_op = CUR_PREV;
                c.cond = C_ALWAYS; c.jump = S_WALK_RD; c.next = S_WALK_RD;
            end
            S_LINK: begin
                c.addr_sel = A_CUR; c.mem_we = 1'b1; c.wd_sel = WD_PREV;
                c.cur_op = CUR_PREV; c.have_inc = 1'b1;
                c.cond = C_ALWAYS; c.jump = S_NEED_CHK; c.next = S_NEED_CHK;
            end
            S_FAIL: begin
                c.status_set = 1'b1;
                c.cond = C_ALWAYS; c.jump = S_EMIT; c.next = S_EMIT;
            end
            S_EMIT: begin
                c.emit = 1'b1;
                c.cond = C_OUT_BUSY; c.jump = S_EMIT; c.next = S_IDLE;
            end
            default: begin
                c.cond = C_ALWAYS; c.jump = S_IDLE; c.next = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/fat_cluster_chain_manager_unit.sv
// Cluster chain manager: 16-bit allocation table, extend and free commands.
// Free walks the chain and clears each link; extend walks to the chain end, then scans the
// table first-fit for free entries and appends one cluster per hit until enough are held
// or the scan reaches the limit. The single-port table memory, stepped by the microcode
// sequencer, serialises this work: a new command is taken only after the last result has entered the output register.
// Reset: synchronous, active low; then a clearing pass over the table, no input.
`timescale 1ns / 1ps
`default_nettype none

`include "fat_cluster_chain_manager_unit_macros.svh"

module fat_cluster_chain_manager_unit #(
    parameter int MAX_CLUSTERS = fccm_pkg::DEFAULT_MAX_CLUSTERS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration: clusters_in_use
    input  wire logic                       cfg_wr_en,
    input  wire logic [fccm_pkg::CFG_W-1:0] cfg_wr_data,
    // command input
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [39:0]                s_tdata,  // [15:0] chain_head, [37:16] byte_count
    input  wire logic                       s_tuser,  // [0] command
    // result output
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [15:0]                     m_tdata,  // [15:0] head_out
    output logic                            m_tuser   // [0] status
);

    localparam int HEAD_W = fccm_pkg::HEAD_W;
    localparam int BYTE_W = fccm_pkg::BYTE_W;
    localparam int CFG_W  = fccm_pkg::CFG_W;
    localparam int NEED_W = fccm_pkg::NEED_W;
    localparam int SHIFT  = fccm_pkg::CLUSTER_SHIFT;

    localparam int ADDR_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int SCAN_W = $clog2(MAX_CLUSTERS + 2);
    localparam int LIM_W  = (SCAN_W > CFG_W) ? SCAN_W : CFG_W;
    localparam int CNT_W  = (SCAN_W > NEED_W) ? SCAN_W : NEED_W;

    localparam logic [LIM_W-1:0]    MAX_LIM   = LIM_W'(MAX_CLUSTERS);
    localparam logic [CNT_W-1:0]    MAX_CNT   = CNT_W'(MAX_CLUSTERS);
    localparam logic [HEAD_W:0]     MAX_LINK  = (HEAD_W + 1)'(MAX_CLUSTERS);
    localparam logic [ADDR_W:0]     MAX_ADDR  = (ADDR_W + 1)'(MAX_CLUSTERS);
    localparam logic [SCAN_W-1:0]   CLR_LAST  = SCAN_W'(MAX_CLUSTERS - 1);
    localparam logic [BYTE_W:0]     ROUND_ADD = (BYTE_W + 1)'(fccm_pkg::BYTES_PER_CLUSTER - 1);

    // valid next-cluster link
    function automatic logic link_ok(input logic [HEAD_W-1:0] v);
        link_ok = (v != fccm_pkg::LINK_FREE) && (v != fccm_pkg::LINK_END) &&
                  ({1'b0, v} < MAX_LINK);
    endfunction

    fccm_pkg::step_t step_reg, step_next;
    fccm_pkg::ctrl_t ctrl;

    logic [CFG_W-1:0]  cfg_clusters_reg;
    logic [HEAD_W-1:0] cur_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [CNT_W-1:0]  have_reg;
    logic [NEED_W-1:0] need_reg;
    logic [SCAN_W-1:0] scan_reg;
    logic              is_free_reg;
    logic              head_ok_reg;
    logic              status_reg;
    logic [HEAD_W-1:0] rdata_reg;

    logic              m_tvalid_reg;
    logic [HEAD_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;

    logic [HEAD_W-1:0] mem [MAX_CLUSTERS];

    logic              accept;
    logic              out_busy;
    logic              emit_fire;
    logic              cond_hit;
    logic              mem_we_eff;
    logic [ADDR_W-1:0] mem_addr;
    logic [HEAD_W-1:0] mem_wdata;
    logic [SCAN_W-1:0] prev;
    logic [LIM_W-1:0]  cfg_ext;
    logic [LIM_W-1:0]  lim;
    logic [BYTE_W:0]   round_sum;
    logic [NEED_W-1:0] need_q;
    logic [NEED_W-1:0] need_in;

    // control word of the current step
    assign ctrl      = fccm_pkg::ucode(step_reg);
    assign accept    = ctrl.ready && s_tvalid;
    assign out_busy  = m_tvalid_reg && !m_tready;
    assign emit_fire = ctrl.emit && !out_busy;
    assign prev      = scan_reg - SCAN_W'(1);

    // search limit: clusters_in_use capped at table size
    assign cfg_ext = LIM_W'(cfg_clusters_reg);
    assign lim     = (cfg_ext > MAX_LIM) ? MAX_LIM : cfg_ext;

    // clusters needed: ceil(bytes / cluster size), at least one
    assign round_sum = {1'b0, s_tdata[37:16]} + ROUND_ADD;
    assign need_q    = round_sum[BYTE_W:SHIFT];
    assign need_in   = (need_q == '0) ? NEED_W'(1) : need_q;

    // jump conditions
    always_comb begin
        unique case (ctrl.cond)
            fccm_pkg::C_ALWAYS:    cond_hit = 1'b1;
            fccm_pkg::C_CLR_MORE:  cond_hit = (scan_reg != CLR_LAST);
            fccm_pkg::C_NO_INPUT:  cond_hit = !s_tvalid;
            fccm_pkg::C_IS_FREE:   cond_hit = is_free_reg;
            fccm_pkg::C_FREE_STOP: cond_hit = !link_ok(cur_reg) || (have_reg > MAX_CNT);
            fccm_pkg::C_CUR_LINK:  cond_hit = link_ok(cur_reg);
            fccm_pkg::C_WALK_STOP: cond_hit = !((have_reg < MAX_CNT) && link_ok(rdata_reg));
            fccm_pkg::C_ENOUGH:    cond_hit = (have_reg >= CNT_W'(need_reg));
            fccm_pkg::C_SCAN_END:  cond_hit = (LIM_W'(scan_reg) >= lim);
            fccm_pkg::C_RD_USED:   cond_hit = (rdata_reg != fccm_pkg::LINK_FREE);
            fccm_pkg::C_HEAD_OK:   cond_hit = head_ok_reg;
            fccm_pkg::C_OUT_BUSY:  cond_hit = out_busy;
            default:               cond_hit = 1'b1;
        endcase
    end

    assign step_next = cond_hit ? ctrl.jump : ctrl.next;

    // step counter; restarts with the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= fccm_pkg::S_CLR;
        end else begin
            step_reg <= step_next;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_clusters_reg <= fccm_pkg::CLUSTERS_RESET;
        end else if (cfg_wr_en) begin
            cfg_clusters_reg <= cfg_wr_data;
        end
    end

    // memory address and write data
    always_comb begin
        unique case (ctrl.addr_sel)
            fccm_pkg::A_CUR:   mem_addr = cur_reg[ADDR_W-1:0];
            fccm_pkg::A_SCAN:  mem_addr = scan_reg[ADDR_W-1:0];
            fccm_pkg::A_PREV:  mem_addr = prev[ADDR_W-1:0];
            fccm_pkg::A_RDATA: mem_addr = rdata_reg[ADDR_W-1:0];
            default:           mem_addr = cur_reg[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        unique case (ctrl.wd_sel)
            fccm_pkg::WD_ZERO: mem_wdata = fccm_pkg::LINK_FREE;
            fccm_pkg::WD_END:  mem_wdata = fccm_pkg::LINK_END;
            fccm_pkg::WD_PREV: mem_wdata = HEAD_W'(prev);
            default:           mem_wdata = fccm_pkg::LINK_FREE;
        endcase
    end

    assign mem_we_eff = ctrl.mem_we && aresetn;

    // allocation table, one port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we_eff) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // scan pointer: clear address, then first-fit position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
        end else if (accept) begin
            scan_reg <= SCAN_W'(1);
        end else if (ctrl.scan_inc) begin
            scan_reg <= scan_reg + SCAN_W'(1);
        end
    end

    // command control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_ok_reg <= 1'b0;
            is_free_reg <= 1'b0;
        end else if (accept) begin
            head_ok_reg <= 1'b0;
            is_free_reg <= (s_tuser == fccm_pkg::CMD_FREE);
        end else if (ctrl.head_load) begin
            head_ok_reg <= 1'b1;
        end
    end

    // chain datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_reg    <= s_tdata[15:0];
            head_reg   <= fccm_pkg::LINK_END;
            have_reg   <= CNT_W'(1);
            need_reg   <= need_in;
            status_reg <= fccm_pkg::STAT_OK;
        end else begin
            case (ctrl.cur_op)
                fccm_pkg::CUR_RDATA: cur_reg <= rdata_reg;
                fccm_pkg::CUR_PREV:  cur_reg <= HEAD_W'(prev);
                default:             cur_reg <= cur_reg;
            endcase
            if (ctrl.have_inc) begin
                have_reg <= have_reg + CNT_W'(1);
            end
            if (ctrl.head_load) begin
                head_reg <= cur_reg;
            end
            if (ctrl.status_set) begin
                status_reg <= fccm_pkg::STAT_NO_SPACE;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_tdata_reg <= head_reg;
            m_tuser_reg <= status_reg;
        end
    end

    assign s_tready = ctrl.ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `FCCM_ASSERT_NXT(a_accept_dispatch, accept, step_reg == fccm_pkg::S_DISP)
    `FCCM_ASSERT_IMP(a_write_in_table, mem_we_eff, {1'b0, mem_addr} < MAX_ADDR)
    `FCCM_ASSERT_IMP(a_link_only_short, step_reg == fccm_pkg::S_LINK, have_reg < CNT_W'(need_reg))
    `FCCM_ASSERT_IMP(a_head_is_link, head_ok_reg, link_ok(head_reg))

endmodule

`default_nettype wire
